// ----- src/assert_macros.svh -----
// assertion helpers included by epaper_line_formatter_unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge while out of reset
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- src/eplf_pkg.sv -----
`timescale 1ns / 1ps
package eplf_pkg;

  localparam int unsigned DEF_MAX_LINE_BYTES = 64;
  localparam int unsigned DEF_MAX_SCAN_BYTES = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int LINE_W    = 15;
  localparam int INDEX_W   = 6;

  localparam logic [7:0]  BYTE_AA = 8'haa;
  localparam logic [7:0]  BYTE_55 = 8'h55;
  localparam logic [15:0] WORD_AA = 16'haaaa;
  localparam logic [15:0] WORD_55 = 16'h5555;
  localparam logic [7:0]  SCAN_LO = 8'h03;
  localparam logic [7:0]  SCAN_HI = 8'hc0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_BYTES  = 3'd0,
    CFG_SCAN_BYTES  = 3'd1,
    CFG_MIDDLE_SCAN = 3'd2,
    CFG_LEAD_ZERO   = 3'd3,
    CFG_BORDER_MODE = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_EMIT  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAGE_COMPENSATE = 2'd0,
    STAGE_WHITE      = 2'd1,
    STAGE_INVERSE    = 2'd2,
    STAGE_NORMAL     = 2'd3
  } stage_e;

  typedef enum logic [1:0] {
    BORDER_NONE = 2'd0,
    BORDER_ZERO = 2'd1,
    BORDER_MARK = 2'd2
  } border_e;

  // where an output byte comes from
  typedef enum logic [2:0] {
    KIND_CONST   = 3'd0,
    KIND_ODD     = 3'd1,
    KIND_EVEN    = 3'd2,
    KIND_WORD_HI = 3'd3,
    KIND_WORD_LO = 3'd4
  } kind_e;

  // byte selection handed from the position stage to the code stage
  typedef struct packed {
    kind_e      kind;
    logic [7:0] const_byte;
    stage_e     stage;
    logic       use_previous;
  } sel_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [INDEX_W-1:0] byte_index;
    logic [7:0]        image_byte;
    logic [7:0]        previous_byte;
    logic [LINE_W-1:0] line_number;
    logic [1:0]        drive_stage;
    logic              use_image;
    logic              use_previous;
    logic [7:0]        fill_value;
  } in_item_t;

  // pixel bit i moves to bit 2i
  function automatic logic [15:0] spread_bits(input logic [7:0] v);
    logic [15:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[2*i] = v[i];
    end
    return r;
  endfunction

endpackage

// ----- src/eplf_intf.sv -----
`timescale 1ns / 1ps
interface eplf_in_if import eplf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic [INDEX_W-1:0]  byte_index;
  logic [7:0]          image_byte;
  logic [7:0]          previous_byte;
  logic [LINE_W-1:0]   line_number;
  logic [1:0]          drive_stage;
  logic                use_image;
  logic                use_previous;
  logic [7:0]          fill_value;

  modport source (
    output valid, command, byte_index, image_byte, previous_byte, line_number,
           drive_stage, use_image, use_previous, fill_value,
    input  ready
  );
  modport sink (
    input  valid, command, byte_index, image_byte, previous_byte, line_number,
           drive_stage, use_image, use_previous, fill_value,
    output ready
  );
endinterface

interface eplf_out_if ();
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink (input valid, out_byte, last_byte, output ready);
endinterface

// ----- src/eplf_code_gen.sv -----
`timescale 1ns / 1ps
module eplf_code_gen import eplf_pkg::*; (
  input  logic [7:0] image_i,
  input  logic [7:0] previous_i,
  input  sel_t       sel_i,
  output logic [7:0] byte_o
);

  logic [7:0]  e_px, e_t, e_pm, e_cd, e_m;
  logic [7:0]  o_px, o_t, o_pm, o_cd, o_m;
  logic [15:0] w_px, w_t, w_pm, w_cd, w_m;

  // even pixels, pair order reversed
  always_comb begin
    e_px = image_i & BYTE_AA;
    e_t  = (previous_i ^ e_px) & BYTE_AA;
    e_pm = sel_i.use_previous ? (e_t | (e_t >> 1)) : 8'hff;
    case (sel_i.stage)
      STAGE_COMPENSATE: e_cd = BYTE_AA | ((e_px ^ BYTE_AA) >> 1);
      STAGE_WHITE:      e_cd = BYTE_55 + ((e_px ^ BYTE_AA) >> 1);
      STAGE_INVERSE:    e_cd = BYTE_55 | (e_px ^ BYTE_AA);
      default:          e_cd = BYTE_AA | (e_px >> 1);
    endcase
    e_m = (e_cd & e_pm) | (~e_pm & BYTE_55);
  end

  // odd pixels
  always_comb begin
    o_px = image_i & BYTE_55;
    o_t  = (previous_i ^ o_px) & BYTE_55;
    o_pm = sel_i.use_previous ? (o_t | (o_t << 1)) : 8'hff;
    case (sel_i.stage)
      STAGE_COMPENSATE: o_cd = BYTE_AA | (o_px ^ BYTE_55);
      STAGE_WHITE:      o_cd = BYTE_55 + (o_px ^ BYTE_55);
      STAGE_INVERSE:    o_cd = BYTE_55 | ((o_px ^ BYTE_55) << 1);
      default:          o_cd = BYTE_AA | o_px;
    endcase
    o_m = (o_cd & o_pm) | (~o_pm & BYTE_55);
  end

  // all eight pixels as a 16 bit word
  always_comb begin
    w_px = spread_bits(image_i);
    w_t  = (spread_bits(previous_i) ^ w_px) & WORD_55;
    w_pm = sel_i.use_previous ? (w_t | (w_t << 1)) : 16'hffff;
    case (sel_i.stage)
      STAGE_COMPENSATE: w_cd = WORD_AA | (w_px ^ WORD_55);
      STAGE_WHITE:      w_cd = WORD_55 + (w_px ^ WORD_55);
      STAGE_INVERSE:    w_cd = WORD_55 | ((w_px ^ WORD_55) << 1);
      default:          w_cd = WORD_AA | w_px;
    endcase
    w_m = (w_cd & w_pm) | (~w_pm & WORD_55);
  end

  always_comb begin
    case (sel_i.kind)
      KIND_ODD:     byte_o = o_m;
      KIND_EVEN:    byte_o = {e_m[1:0], e_m[3:2], e_m[5:4], e_m[7:6]};
      KIND_WORD_HI: byte_o = w_m[15:8];
      KIND_WORD_LO: byte_o = w_m[7:0];
      default:      byte_o = sel_i.const_byte;
    endcase
  end

endmodule

// ----- src/epaper_line_formatter_unit.sv -----
`timescale 1ns / 1ps
// e-paper line formatter: load requests fill a line store of image and
// previous-image bytes, a begin request latches line number, drive stage,
// fill value and mask choice, and every emit request returns the next byte
// of the panel line (optional lead zero, drive-code and one-hot scan bytes
// in middle-scan or split-scan order, optional border byte), with last_byte
// on the final one. one request is taken every cycle unless the input
// stalls; an emit result passes from the input register through the line
// store read register to the output register. each stage moves when the
// stage after it is empty or moving, so bubbles are squeezed out and the
// input stalls only when the input stage, the code stage and the output
// register are all full and the output is not taken. loads, begins and
// emits past the end of a line give no result. the store has no reset and
// no clearing pass: bytes must be loaded before they are driven.
// configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write it only while no request is in flight, the block has no check for this.
module epaper_line_formatter_unit import eplf_pkg::*; #(
  parameter int unsigned MAX_LINE_BYTES = DEF_MAX_LINE_BYTES,
  parameter int unsigned MAX_SCAN_BYTES = DEF_MAX_SCAN_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  eplf_in_if.sink              in_if,
  eplf_out_if.source           out_if
);

`include "assert_macros.svh"

  // position counter holds up to the longest line length
  localparam int POS_W = $clog2(2 * MAX_LINE_BYTES + 2 * MAX_SCAN_BYTES + 3);
  localparam int AW    = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;

  // configuration
  logic [CFG_W-1:0] cfg_line_q, cfg_scan_q;
  logic             cfg_mid_q, cfg_lead_q;
  border_e          cfg_border_q;

  // held line state
  logic [LINE_W-1:0] held_line_q;
  stage_e            held_stage_q;
  logic              held_use_img_q, held_use_prev_q;
  logic [7:0]        held_fill_q;
  logic [POS_W-1:0]  emit_pos_q;
  logic              active_q;

  // pipeline
  logic       v1_q, v2_q, ov_q;
  in_item_t   item_q;
  sel_t       sel_d, sel_q;
  logic       last_d, last2_q, last_q;
  logic [7:0] out_byte_q, code_byte;
  logic [15:0] rdata_q;

  // line store: image byte in the upper half, previous byte in the lower
  logic [15:0] store_mem [MAX_LINE_BYTES];

  logic adv_out, adv2, fire1;
  logic is_load, is_begin, is_emit, produce, store_we;

  logic [POS_W-1:0] eff_l, eff_s, total, pos_rel, addr_full, scan_b, q_rel, pos_next;
  logic [15:0]      eff_l16, eff_s16;
  logic             border_on, scan_hit;
  logic [7:0]       tail_byte;

  // handshakes: a stage moves when the one after it is empty or moving
  assign adv_out     = !ov_q || out_if.ready;
  assign adv2        = !v2_q || adv_out;
  assign in_if.ready = !v1_q || adv2;
  assign fire1       = v1_q && adv2;

  assign out_if.valid     = ov_q;
  assign out_if.out_byte  = out_byte_q;
  assign out_if.last_byte = last_q;

  // effective lengths saturate at the store and scan sizes
  assign eff_l16 = (16'(cfg_line_q) > 16'(MAX_LINE_BYTES)) ? 16'(MAX_LINE_BYTES)
                                                            : 16'(cfg_line_q);
  assign eff_s16 = (16'(cfg_scan_q) > 16'(MAX_SCAN_BYTES)) ? 16'(MAX_SCAN_BYTES)
                                                            : 16'(cfg_scan_q);
  assign eff_l   = eff_l16[POS_W-1:0];
  assign eff_s   = eff_s16[POS_W-1:0];

  assign border_on = (cfg_border_q == BORDER_ZERO) || (cfg_border_q == BORDER_MARK);
  assign tail_byte = ((cfg_border_q == BORDER_MARK) && (held_stage_q == STAGE_NORMAL))
                     ? BYTE_AA : 8'h00;

  assign total = POS_W'(cfg_lead_q) + (eff_l << 1) + (cfg_mid_q ? eff_s : (eff_s << 1))
               + POS_W'(border_on);

  assign is_load  = (item_q.command == CMD_LOAD);
  assign is_begin = (item_q.command == CMD_BEGIN);
  assign is_emit  = (item_q.command == CMD_EMIT);
  assign produce  = is_emit && active_q && (emit_pos_q < total);
  assign pos_next = emit_pos_q + POS_W'(1);
  assign last_d   = (pos_next == total);
  assign store_we = fire1 && is_load && (16'(item_q.byte_index) < 16'(MAX_LINE_BYTES));

  // byte selection for the current position
  always_comb begin
    sel_d.kind         = KIND_CONST;
    sel_d.const_byte   = 8'h00;
    sel_d.stage        = held_stage_q;
    sel_d.use_previous = held_use_prev_q;
    pos_rel   = emit_pos_q - POS_W'(cfg_lead_q);
    addr_full = '0;
    scan_b    = '0;
    q_rel     = '0;
    scan_hit  = 1'b0;
    if (cfg_lead_q && (emit_pos_q == '0)) begin
      sel_d.const_byte = 8'h00;
    end else if (cfg_mid_q) begin
      // odd pixels reversed, scan group, even pixels
      if (pos_rel < eff_l) begin
        addr_full = eff_l - POS_W'(1) - pos_rel;
        if (held_use_img_q) sel_d.kind = KIND_ODD;
        else sel_d.const_byte = held_fill_q;
      end else if (pos_rel < eff_l + eff_s) begin
        scan_b   = eff_l + eff_s - POS_W'(1) - pos_rel;
        scan_hit = (16'(held_line_q[LINE_W-1:2]) == 16'(scan_b));
        sel_d.const_byte = scan_hit ? (SCAN_LO << {held_line_q[1:0], 1'b0}) : 8'h00;
      end else if (pos_rel < (eff_l << 1) + eff_s) begin
        addr_full = pos_rel - eff_l - eff_s;
        if (held_use_img_q) sel_d.kind = KIND_EVEN;
        else sel_d.const_byte = held_fill_q;
      end else begin
        sel_d.const_byte = tail_byte;
      end
    end else begin
      // scan group for odd lines, interleaved pixels, scan group for even lines
      if (pos_rel < eff_s) begin
        scan_hit = held_line_q[0] && (16'(held_line_q[LINE_W-1:3]) == 16'(pos_rel));
        sel_d.const_byte = scan_hit ? (SCAN_HI >> {held_line_q[2:1], 1'b0}) : 8'h00;
      end else if (pos_rel < eff_s + (eff_l << 1)) begin
        q_rel     = pos_rel - eff_s;
        addr_full = eff_l - POS_W'(1) - (q_rel >> 1);
        if (!held_use_img_q) sel_d.const_byte = held_fill_q;
        else if (q_rel[0]) sel_d.kind = KIND_WORD_LO;
        else sel_d.kind = KIND_WORD_HI;
      end else if (pos_rel < (eff_s << 1) + (eff_l << 1)) begin
        scan_b   = (eff_s << 1) + (eff_l << 1) - POS_W'(1) - pos_rel;
        scan_hit = !held_line_q[0] && (16'(held_line_q[LINE_W-1:3]) == 16'(scan_b));
        sel_d.const_byte = scan_hit ? (SCAN_LO << {held_line_q[2:1], 1'b0}) : 8'h00;
      end else begin
        sel_d.const_byte = tail_byte;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_line_q   <= CFG_W'(33);
      cfg_scan_q   <= CFG_W'(44);
      cfg_mid_q    <= 1'b1;
      cfg_lead_q   <= 1'b0;
      cfg_border_q <= BORDER_NONE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LINE_BYTES:  cfg_line_q   <= cfg_data_i;
        CFG_SCAN_BYTES:  cfg_scan_q   <= cfg_data_i;
        CFG_MIDDLE_SCAN: cfg_mid_q    <= cfg_data_i[0];
        CFG_LEAD_ZERO:   cfg_lead_q   <= cfg_data_i[0];
        CFG_BORDER_MODE: cfg_border_q <= border_e'(cfg_data_i[1:0]);
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_if.ready) begin
      v1_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q.command       <= in_if.command;
      item_q.byte_index    <= in_if.byte_index;
      item_q.image_byte    <= in_if.image_byte;
      item_q.previous_byte <= in_if.previous_byte;
      item_q.line_number   <= in_if.line_number;
      item_q.drive_stage   <= in_if.drive_stage;
      item_q.use_image     <= in_if.use_image;
      item_q.use_previous  <= in_if.use_previous;
      item_q.fill_value    <= in_if.fill_value;
    end
  end

  // held line state, position and active flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_line_q     <= '0;
      held_stage_q    <= STAGE_COMPENSATE;
      held_use_img_q  <= 1'b0;
      held_use_prev_q <= 1'b0;
      held_fill_q     <= '0;
      emit_pos_q      <= '0;
      active_q        <= 1'b0;
    end else if (fire1) begin
      if (is_begin) begin
        held_line_q     <= item_q.line_number;
        held_stage_q    <= stage_e'(item_q.drive_stage);
        held_use_img_q  <= item_q.use_image;
        held_use_prev_q <= item_q.use_previous;
        held_fill_q     <= item_q.fill_value;
        emit_pos_q      <= '0;
        active_q        <= 1'b1;
      end else if (is_emit && active_q) begin
        if (produce) begin
          emit_pos_q <= pos_next;
          if (pos_next >= total) active_q <= 1'b0;
        end else begin
          // line got shorter than what was already sent
          active_q <= 1'b0;
        end
      end
    end
  end

  // line store, read data registered into the code stage
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[AW'(item_q.byte_index)] <= {item_q.image_byte, item_q.previous_byte};
    end
    if (fire1 && produce) begin
      rdata_q <= store_mem[addr_full[AW-1:0]];
    end
  end

  // code stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= fire1 && produce;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1 && produce) begin
      sel_q   <= sel_d;
      last2_q <= last_d;
    end
  end

  eplf_code_gen u_code_gen (
    .image_i    (rdata_q[15:8]),
    .previous_i (rdata_q[7:0]),
    .sel_i      (sel_q),
    .byte_o     (code_byte)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (adv_out) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && v2_q) begin
      out_byte_q <= code_byte;
      last_q     <= last2_q;
    end
  end

  // an emit that yields a byte reaches the code stage next cycle
  `ASSERT_CLK(a_emit_to_code, (fire1 && produce) |=> v2_q, "emit result lost before code stage")
  // the final byte of a line closes the line
  `ASSERT_CLK(a_last_closes, (fire1 && produce && last_d) |=> !active_q,
              "line still active after its final byte")
  // a full, stalled pipeline takes no request
  `ASSERT_CLK(a_full_stall, (v1_q && v2_q && ov_q && !out_if.ready) |-> !in_if.ready,
              "request taken while pipeline is full")

endmodule
